/* hdl/jsud_pkg.sv */
// Shared types, character codes and UTF-8 helpers for the JSON string unescape decoder.
`timescale 1ns / 1ps

package jsud_pkg;

   // Character codes seen in the string body
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOW_B  = 8'h62;
   localparam logic [7:0] CHAR_LOW_F  = 8'h66;
   localparam logic [7:0] CHAR_LOW_N  = 8'h6E;
   localparam logic [7:0] CHAR_LOW_R  = 8'h72;
   localparam logic [7:0] CHAR_LOW_T  = 8'h74;
   localparam logic [7:0] CHAR_LOW_U  = 8'h75;

   // Control characters produced by escapes
   localparam logic [7:0] CTRL_BS = 8'h08;
   localparam logic [7:0] CTRL_FF = 8'h0C;
   localparam logic [7:0] CTRL_LF = 8'h0A;
   localparam logic [7:0] CTRL_CR = 8'h0D;
   localparam logic [7:0] CTRL_HT = 8'h09;

   // UTF-8 lead and continuation markers
   localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
   localparam logic [7:0]  UTF8_CONT   = 8'h80;
   localparam logic [7:0]  UTF8_MASK6  = 8'h3F;
   localparam logic [15:0] UTF8_LIM1   = 16'h0080;
   localparam logic [15:0] UTF8_LIM2   = 16'h0800;

   // Number of bytes taken after a \u escape
   localparam logic [2:0] HEX_BYTES = 3'd4;

   // One queued command: up to three result transactions from one input item
   typedef struct packed {
      logic [1:0] count;     // number of results, 1 to 3
      logic [7:0] byte2;
      logic [7:0] byte1;
      logic [7:0] byte0;
      logic       has_byte;  // results carry decoded bytes
      logic       done;      // last result finishes the string
      logic       quote;     // string finished by a closing quote
   } jsud_cmd_type;

   typedef struct packed {
      logic [1:0] count;
      logic [7:0] byte2;
      logic [7:0] byte1;
      logic [7:0] byte0;
   } jsud_utf8_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] digit;
   } jsud_hex_type;

   // Encode a 16-bit code point as 1 to 3 UTF-8 bytes
   function automatic jsud_utf8_type utf8_encode(input logic [15:0] cp);
      jsud_utf8_type r;
      r = '0;
      if (cp < UTF8_LIM1) begin
         r.count = 2'd1;
         r.byte0 = cp[7:0];
      end else if (cp < UTF8_LIM2) begin
         r.count = 2'd2;
         r.byte0 = UTF8_LEAD2 | {3'b000, cp[10:6]};
         r.byte1 = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_MASK6);
      end else begin
         r.count = 2'd3;
         r.byte0 = UTF8_LEAD3 | {4'b0000, cp[15:12]};
         r.byte1 = UTF8_CONT | ({2'b00, cp[11:6]} & UTF8_MASK6);
         r.byte2 = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_MASK6);
      end
      return r;
   endfunction

   // Classify a byte as a hex digit and give its value
   function automatic jsud_hex_type hex_decode(input logic [7:0] c);
      jsud_hex_type r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.ok    = 1'b1;
         r.digit = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.ok    = 1'b1;
         r.digit = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.ok    = 1'b1;
         r.digit = 4'(c - 8'h37);
      end
      return r;
   endfunction

endpackage

/* hdl/jsud_if.sv */
// Request and response channel interfaces of the JSON string unescape decoder.
`timescale 1ns / 1ps

interface jsud_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_text;

   modport source(output valid, data_byte, end_of_text, input ready);
   modport sink(input valid, data_byte, end_of_text, output ready);
endinterface

interface jsud_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       string_done;
   logic       closed_by_quote;
   logic       last_of_item;

   modport source(output valid, out_byte, byte_valid, string_done, closed_by_quote,
                  last_of_item, input ready);
   modport sink(input valid, out_byte, byte_valid, string_done, closed_by_quote,
                last_of_item, output ready);
endinterface

/* hdl/jsud_front.sv */
// Front end: accepts raw bytes, tracks escape state and queues result commands.
`timescale 1ns / 1ps

module jsud_front
   import jsud_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   jsud_req_if.sink     req_chan,
   input  logic         cmd_full,
   output logic         cmd_push,
   output jsud_cmd_type cmd_data
);

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESCAPE = 2'd1;
   localparam logic [1:0] MODE_HEX    = 2'd2;

   logic [1:0]    mode_ff, mode_in;
   logic [15:0]   hex_value_ff, hex_value_in;
   logic [2:0]    hex_count_ff, hex_count_in;
   logic          hex_stopped_ff, hex_stopped_in;
   logic          accept;
   jsud_hex_type  hd;
   logic          hex_take;
   logic [15:0]   hex_next;
   logic [2:0]    count_next;
   logic [7:0]    esc_byte;
   jsud_utf8_type enc;

   assign req_chan.ready = !cmd_full;
   assign accept         = req_chan.valid && !cmd_full;

   // Map the byte after a backslash
   always_comb begin
      unique case (req_chan.data_byte)
         CHAR_LOW_B: esc_byte = CTRL_BS;
         CHAR_LOW_F: esc_byte = CTRL_FF;
         CHAR_LOW_N: esc_byte = CTRL_LF;
         CHAR_LOW_R: esc_byte = CTRL_CR;
         CHAR_LOW_T: esc_byte = CTRL_HT;
         default:    esc_byte = req_chan.data_byte;
      endcase
   end

   // Accumulate hex digits until the first non-digit
   assign hd         = hex_decode(req_chan.data_byte);
   assign hex_take   = !hex_stopped_ff && hd.ok;
   assign hex_next   = hex_take ? {hex_value_ff[11:0], hd.digit} : hex_value_ff;
   assign count_next = hex_count_ff + 3'd1;
   assign enc        = utf8_encode(req_chan.end_of_text ? hex_value_ff : hex_next);

   // Decode the accepted byte and build the queued command
   always_comb begin
      mode_in        = mode_ff;
      hex_value_in   = hex_value_ff;
      hex_count_in   = hex_count_ff;
      hex_stopped_in = hex_stopped_ff;
      cmd_push       = 1'b0;
      cmd_data       = '0;
      cmd_data.count = 2'd1;
      unique case (mode_ff)
         MODE_ESCAPE: begin
            if (req_chan.end_of_text) begin
               cmd_push          = 1'b1;
               cmd_data.has_byte = 1'b1;
               cmd_data.done     = 1'b1;
               mode_in           = MODE_NORMAL;
            end else if (req_chan.data_byte == CHAR_LOW_U) begin
               mode_in        = MODE_HEX;
               hex_value_in   = '0;
               hex_count_in   = '0;
               hex_stopped_in = 1'b0;
            end else begin
               cmd_push          = 1'b1;
               cmd_data.has_byte = 1'b1;
               cmd_data.byte0    = esc_byte;
               mode_in           = MODE_NORMAL;
            end
         end
         MODE_HEX: begin
            if (req_chan.end_of_text || count_next >= HEX_BYTES) begin
               cmd_push          = 1'b1;
               cmd_data.has_byte = 1'b1;
               cmd_data.count    = enc.count;
               cmd_data.byte0    = enc.byte0;
               cmd_data.byte1    = enc.byte1;
               cmd_data.byte2    = enc.byte2;
               cmd_data.done     = req_chan.end_of_text;
               mode_in           = MODE_NORMAL;
               hex_value_in      = '0;
               hex_count_in      = '0;
               hex_stopped_in    = 1'b0;
            end else begin
               hex_value_in   = hex_next;
               hex_count_in   = count_next;
               hex_stopped_in = !hex_take;
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
            if (req_chan.end_of_text) begin
               cmd_push      = 1'b1;
               cmd_data.done = 1'b1;
            end else if (req_chan.data_byte == CHAR_QUOTE) begin
               cmd_push       = 1'b1;
               cmd_data.done  = 1'b1;
               cmd_data.quote = 1'b1;
            end else if (req_chan.data_byte == CHAR_BSLASH) begin
               mode_in = MODE_ESCAPE;
            end else begin
               cmd_push          = 1'b1;
               cmd_data.has_byte = 1'b1;
               cmd_data.byte0    = req_chan.data_byte;
            end
         end
      endcase
      if (!accept) begin
         cmd_push = 1'b0;
      end
   end

   // Advance decode state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_NORMAL;
         hex_value_ff   <= '0;
         hex_count_ff   <= '0;
         hex_stopped_ff <= 1'b0;
      end else if (accept) begin
         mode_ff        <= mode_in;
         hex_value_ff   <= hex_value_in;
         hex_count_ff   <= hex_count_in;
         hex_stopped_ff <= hex_stopped_in;
      end
   end

endmodule

/* hdl/jsud_fifo.sv */
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module jsud_fifo
   import jsud_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  jsud_cmd_type push_data,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output jsud_cmd_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jsud_cmd_type      entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed commands
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("command pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("command popped from empty queue");

endmodule

/* hdl/jsud_back.sv */
// Back end: expands queued commands into response transactions through an output register.
`timescale 1ns / 1ps

module jsud_back
   import jsud_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  jsud_cmd_type head_data,
   output logic         pop,
   jsud_rsp_if.source   rsp_chan
);

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       byte_valid_ff, byte_valid_in;
   logic       done_ff, done_in;
   logic       quote_ff, quote_in;
   logic       last_ff, last_in;
   logic       load;
   logic       is_last;
   logic [7:0] sel_byte;

   assign load    = !rsp_valid_ff || rsp_chan.ready;
   assign is_last = (idx_ff == head_data.count - 2'd1);

   // Pick the byte of the current result within the command
   always_comb begin
      case (idx_ff)
         2'd1:    sel_byte = head_data.byte1;
         2'd2:    sel_byte = head_data.byte2;
         default: sel_byte = head_data.byte0;
      endcase
   end

   // Load the next result into the output register; drop the command after its last
   always_comb begin
      pop           = 1'b0;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      done_in       = done_ff;
      quote_in      = quote_ff;
      last_in       = last_ff;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            out_byte_in   = head_data.has_byte ? sel_byte : 8'h00;
            byte_valid_in = head_data.has_byte;
            done_in       = head_data.done && is_last;
            quote_in      = head_data.done && head_data.quote && is_last;
            last_in       = is_last;
            pop           = is_last;
            idx_in        = is_last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      done_ff       <= done_in;
      quote_ff      <= quote_in;
      last_ff       <= last_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.out_byte        = out_byte_ff;
   assign rsp_chan.byte_valid      = byte_valid_ff;
   assign rsp_chan.string_done     = done_ff;
   assign rsp_chan.closed_by_quote = quote_ff;
   assign rsp_chan.last_of_item    = last_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (idx_ff < head_data.count))
      else $error("result index beyond command length");

   a_item_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !last_ff) |=> rsp_valid_ff)
      else $error("gap inside the results of one item");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> last_ff)
      else $error("string finished before the last result of its item");

endmodule

/* hdl/json_string_unescape_decoder.sv */
// Top level of the JSON string unescape decoder.
`timescale 1ns / 1ps

// Decodes the body of a JSON string, one byte per request transaction, into
// unescaped bytes, with \u escapes turned into 1 to 3 UTF-8 bytes. A request
// is taken every cycle while the command queue has room; a request that
// yields results has its command written into the queue, and its first
// result then moves from the queue head into the output register.
// The response port delivers one transaction per cycle while it is ready, so
// an item with a two- or three-byte \u expansion occupies the output register
// for one transaction per byte, and the queue of QUEUE_DEPTH commands absorbs
// those bursts and any response stalls. Items with no result (a backslash, the
// first bytes of a \u escape) reach the queue not at all.
module json_string_unescape_decoder
   import jsud_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   jsud_req_if.sink   req_chan,
   jsud_rsp_if.source rsp_chan
);

   logic         cmd_push;
   logic         cmd_full;
   logic         cmd_pop;
   logic         head_valid;
   jsud_cmd_type cmd_data;
   jsud_cmd_type head_data;

   jsud_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_data)
   );

   jsud_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_data),
      .full       (cmd_full),
      .pop        (cmd_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   jsud_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (cmd_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
